// ===== hw/rtl/smq_pkg.sv =====
// Shared types and codes for the slotted message queue.
package smq_pkg;

  // Default geometry of the slot ring
  localparam int unsigned NumSlotsDefault  = 16;
  localparam int unsigned SlotBytesDefault = 256;

  // Configuration register indexes
  localparam logic CFG_SLOTS_IN_USE = 1'b0;
  localparam logic CFG_SLOT_SIZE    = 1'b1;

  // Configuration register reset values
  localparam logic [4:0] SlotsInUseReset = 5'd16;
  localparam logic [8:0] SlotSizeReset   = 9'd256;

  typedef enum logic [2:0] {
    ACT_WRITE_BYTE = 3'd0,
    ACT_PUSH       = 3'd1,
    ACT_READ_BYTE  = 3'd2,
    ACT_RELEASE    = 3'd3,
    ACT_FLUSH      = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_TOO_SMALL = 3'd4
  } status_e;

  // Byte memory access request
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ram_req_t;

  // Result beat from the ring controller
  typedef struct packed {
    logic        done;
    status_e     status;
    logic [8:0]  msg_length;
    logic [12:0] pending_total;
    logic        is_empty;
    logic        is_full;
    logic        rd_hit;
  } result_t;

endpackage

// ===== hw/rtl/slotted_message_queue_core.sv =====
// Top level of the slotted message queue: controller plus slot byte memory.
//
// The block takes one command on every clock edge where start is high and
// answers each with exactly one result beat, marked by done_o, in the cycle
// right after the command; busy stays low, so a new command may follow
// every cycle. The receiver cannot hold a result off: each beat sits on the
// result ports for exactly one cycle and must be taken at the edge that ends
// it. Ring pointers, valid marks and lengths live in flip-flops and
// are updated at the command edge; payload bytes sit in one synchronous
// memory of NumSlots x SlotBytes bytes whose registered read data comes out
// with the result beat. Status, lengths, pending total and the empty/full
// flags are valid only while done_o is high. Writing a configuration
// register flushes the queue and must happen only while no command is in
// flight.
module slotted_message_queue_core
  import smq_pkg::*;
#(
  parameter int unsigned NumSlots  = NumSlotsDefault,
  parameter int unsigned SlotBytes = SlotBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  byte_offset_i,
  input  logic [8:0]  length_i,
  input  logic [3:0]  entry_index_i,
  input  logic [8:0]  capacity_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [7:0]  data_out_o,
  output logic [8:0]  msg_length_o,
  output logic [12:0] pending_total_o,
  output logic        is_empty_o,
  output logic        is_full_o
);

  localparam int unsigned Depth = NumSlots * SlotBytes;
  localparam int unsigned AddrW = $clog2(Depth);

  ram_req_t         ram_req;
  logic [AddrW-1:0] ram_addr;
  logic [7:0]       ram_rdata;
  result_t          result;
  logic             accept;

  // No command ever stalls the block
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  smq_ctrl #(
    .NumSlots  (NumSlots),
    .SlotBytes (SlotBytes),
    .AddrW     (AddrW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .action_i      (action_i),
    .byte_offset_i (byte_offset_i),
    .length_i      (length_i),
    .entry_index_i (entry_index_i),
    .capacity_i    (capacity_i),
    .ram_req_o     (ram_req),
    .ram_addr_o    (ram_addr),
    .result_o      (result)
  );

  smq_byte_ram #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_byte_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .addr_i  (ram_addr),
    .wdata_i (data_byte_i),
    .rdata_o (ram_rdata)
  );

  // Drive the result beat; data only on a successful read
  assign done_o          = result.done;
  assign status_o        = result.status;
  assign data_out_o      = result.rd_hit ? ram_rdata : 8'd0;
  assign msg_length_o    = result.msg_length;
  assign pending_total_o = result.pending_total;
  assign is_empty_o      = result.is_empty;
  assign is_full_o       = result.is_full;

endmodule

// ===== hw/rtl/smq_byte_ram.sv =====
// Single-port synchronous byte memory holding the slot payloads.
module smq_byte_ram
  import smq_pkg::*;
#(
  parameter int unsigned Depth = NumSlotsDefault * SlotBytesDefault,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  ram_req_t         req_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [7:0]       wdata_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  // Write on request, register read data
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[addr_i] <= wdata_i;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/smq_ctrl.sv =====
// Ring controller: slot valid marks, lengths, pointers, running total, status.
module smq_ctrl
  import smq_pkg::*;
#(
  parameter int unsigned NumSlots  = NumSlotsDefault,
  parameter int unsigned SlotBytes = SlotBytesDefault,
  parameter int unsigned AddrW     = $clog2(NumSlots * SlotBytes)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [8:0]       cfg_wdata_i,
  input  logic             accept_i,
  input  logic [2:0]       action_i,
  input  logic [7:0]       byte_offset_i,
  input  logic [8:0]       length_i,
  input  logic [3:0]       entry_index_i,
  input  logic [8:0]       capacity_i,
  output ram_req_t         ram_req_o,
  output logic [AddrW-1:0] ram_addr_o,
  output result_t          result_o
);

  localparam int unsigned SlotW  = $clog2(NumSlots);
  localparam int unsigned CntW   = $clog2(NumSlots + 1);
  localparam int unsigned RingCw = (CntW > 5) ? CntW : 5;
  localparam int unsigned SizeCw = ($clog2(SlotBytes + 1) > 9) ? $clog2(SlotBytes + 1) : 9;
  localparam int unsigned IdxCw  = ((SlotW > 4) ? SlotW : 4) + 1;
  localparam logic [AddrW-1:0] SlotStride = AddrW'(SlotBytes);

  // Configuration
  logic [4:0] slots_q, slots_d;
  logic [8:0] size_q, size_d;

  // Ring state
  logic             valid_q [NumSlots];
  logic             valid_d [NumSlots];
  logic [8:0]       len_q   [NumSlots];
  logic             len_we;
  logic [SlotW-1:0] write_q, write_d;
  logic [SlotW-1:0] read_q, read_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [12:0]      total_q, total_d;

  // Result registers
  logic    done_q, done_d;
  status_e status_q, status_d;
  logic [8:0] mlen_q, mlen_d;
  logic    rd_hit_q, rd_hit_d;

  logic [RingCw-1:0] ring_wide;
  logic [CntW-1:0]   ring;
  logic [8:0]        eff_size;
  logic [IdxCw-1:0]  idx_sum;
  logic [IdxCw-1:0]  idx_wrap;
  logic [SlotW-1:0]  rd_slot;
  logic [SlotW-1:0]  acc_slot;
  logic              off_ok;
  logic              idx_ok;
  logic [8:0]        head_len;
  logic [8:0]        entry_len;

  function automatic logic [SlotW-1:0] advance(input logic [SlotW-1:0] p,
                                               input logic [CntW-1:0]  n);
    logic [CntW-1:0] nxt;
    nxt = CntW'(p) + CntW'(1);
    return (nxt >= n) ? '0 : nxt[SlotW-1:0];
  endfunction

  // Saturate the register values to the ring geometry
  always_comb begin
    if (slots_q == 5'd0) begin
      ring_wide = RingCw'(1);
    end else if (RingCw'(slots_q) > RingCw'(NumSlots)) begin
      ring_wide = RingCw'(NumSlots);
    end else begin
      ring_wide = RingCw'(slots_q);
    end
    ring = ring_wide[CntW-1:0];
    if (SizeCw'(size_q) > SizeCw'(SlotBytes)) begin
      eff_size = 9'(SlotBytes);
    end else begin
      eff_size = size_q;
    end
  end

  // Locate the idx-th queued slot from the head
  assign idx_sum  = IdxCw'(read_q) + IdxCw'(entry_index_i);
  assign idx_wrap = (idx_sum >= IdxCw'(ring)) ? idx_sum - IdxCw'(ring) : idx_sum;
  assign rd_slot  = idx_wrap[SlotW-1:0];
  assign idx_ok   = (RingCw'(entry_index_i) < RingCw'(count_q));
  assign off_ok   = (9'(byte_offset_i) < eff_size);
  assign head_len  = len_q[read_q];
  assign entry_len = len_q[rd_slot];

  // Byte memory address
  assign acc_slot   = (action_i == ACT_READ_BYTE) ? rd_slot : write_q;
  assign ram_addr_o = AddrW'(acc_slot) * SlotStride + AddrW'(byte_offset_i);

  // Apply a configuration write, or decode the action and compute the next ring state
  always_comb begin
    slots_d   = slots_q;
    size_d    = size_q;
    valid_d   = valid_q;
    len_we    = 1'b0;
    write_d   = write_q;
    read_d    = read_q;
    count_d   = count_q;
    total_d   = total_q;
    done_d    = 1'b0;
    status_d  = ST_OK;
    mlen_d    = '0;
    rd_hit_d  = 1'b0;
    ram_req_o = '0;

    if (cfg_we_i) begin
      if (cfg_idx_i == CFG_SLOTS_IN_USE) begin
        slots_d = cfg_wdata_i[4:0];
      end else begin
        size_d = cfg_wdata_i;
      end
      for (int i = 0; i < NumSlots; i++) valid_d[i] = 1'b0;
      write_d = '0;
      read_d  = '0;
      count_d = '0;
      total_d = '0;
    end else if (accept_i) begin
      done_d = 1'b1;
      unique case (action_i)
        ACT_WRITE_BYTE: begin
          if (valid_q[write_q]) begin
            status_d = ST_FULL;
          end else if (!off_ok) begin
            status_d = ST_TOO_LONG;
          end else begin
            ram_req_o.wr_en = 1'b1;
          end
        end
        ACT_PUSH: begin
          if (length_i > eff_size) begin
            status_d = ST_TOO_LONG;
          end else if (valid_q[write_q]) begin
            status_d = ST_FULL;
          end else begin
            len_we           = 1'b1;
            valid_d[write_q] = 1'b1;
            write_d          = advance(write_q, ring);
            count_d          = count_q + CntW'(1);
            total_d          = total_q + 13'(length_i);
            mlen_d           = length_i;
          end
        end
        ACT_READ_BYTE: begin
          if (!idx_ok) begin
            status_d = ST_EMPTY;
          end else begin
            mlen_d = entry_len;
            if (!off_ok) begin
              status_d = ST_TOO_LONG;
            end else begin
              ram_req_o.rd_en = 1'b1;
              rd_hit_d        = 1'b1;
            end
          end
        end
        ACT_RELEASE: begin
          if (!valid_q[read_q]) begin
            status_d = ST_EMPTY;
          end else begin
            mlen_d = head_len;
            if (head_len > capacity_i) begin
              status_d = ST_TOO_SMALL;
            end else begin
              valid_d[read_q] = 1'b0;
              read_d          = advance(read_q, ring);
              if (count_q != '0) count_d = count_q - CntW'(1);
              total_d = total_q - 13'(head_len);
            end
          end
        end
        ACT_FLUSH: begin
          for (int i = 0; i < NumSlots; i++) valid_d[i] = 1'b0;
          write_d = '0;
          read_d  = '0;
          count_d = '0;
          total_d = '0;
        end
        default: begin
          // Unused action codes leave the state alone
        end
      endcase
    end
  end

  // Hold control state and result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q  <= SlotsInUseReset;
      size_q   <= SlotSizeReset;
      for (int i = 0; i < NumSlots; i++) valid_q[i] <= 1'b0;
      write_q  <= '0;
      read_q   <= '0;
      count_q  <= '0;
      total_q  <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
      rd_hit_q <= 1'b0;
    end else begin
      slots_q  <= slots_d;
      size_q   <= size_d;
      valid_q  <= valid_d;
      write_q  <= write_d;
      read_q   <= read_d;
      count_q  <= count_d;
      total_q  <= total_d;
      done_q   <= done_d;
      status_q <= status_d;
      rd_hit_q <= rd_hit_d;
    end
  end

  // Store committed lengths; only read behind a valid mark
  always_ff @(posedge clk_i) begin
    mlen_q <= mlen_d;
    if (len_we) begin
      len_q[write_q] <= length_i;
    end
  end

  // Ring views are taken after the action has landed
  assign result_o.done          = done_q;
  assign result_o.status        = status_q;
  assign result_o.msg_length    = mlen_q;
  assign result_o.pending_total = total_q;
  assign result_o.is_empty      = ~valid_q[read_q];
  assign result_o.is_full       = valid_q[write_q];
  assign result_o.rd_hit        = rd_hit_q;

endmodule
